@@ rtl/core/pwb_pkg.sv @@
// Shared types and constants for the perspective warp block.
// No dependencies; every other file of the block imports this package.
package pwb_pkg;

    localparam int COORD_W    = 12;
    localparam int BYTE_W     = 8;
    localparam int PIX_W      = 32;
    localparam int COEF_W     = 32;
    localparam int PROD_W     = 45;
    localparam int NUM_W      = 48;
    localparam int FRAC_BITS  = 23;
    localparam int WGT_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int DIM_W      = 11;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_PAIR0 = 3'd0,
        CFG_COEF_PAIR1 = 3'd1,
        CFG_COEF_PAIR2 = 3'd2,
        CFG_COEF_PAIR3 = 3'd3,
        CFG_COEF_LAST  = 3'd4,
        CFG_SRC_WIDTH  = 3'd5,
        CFG_SRC_HEIGHT = 3'd6
    } cfg_idx_t;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_REQUEST = 1'b1
    } op_t;

    typedef struct packed {
        logic [WGT_W-1:0] w00;
        logic [WGT_W-1:0] w10;
        logic [WGT_W-1:0] w01;
        logic [WGT_W-1:0] w11;
    } wgt_t;

    typedef struct packed {
        logic [BYTE_W-1:0] p00;
        logic [BYTE_W-1:0] p10;
        logic [BYTE_W-1:0] p01;
        logic [BYTE_W-1:0] p11;
    } nbr_t;

endpackage

@@ rtl/core/pwb_proj.sv @@
// Pipelined projective divider for both source axes, one quotient bit per stage.
// Depends on pwb_pkg.
module pwb_proj #(
    parameter int K  = 18,
    parameter int PW = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [PW-1:0]                       in_payload,
    input  logic signed [pwb_pkg::NUM_W-1:0]    in_nx,
    input  logic signed [pwb_pkg::NUM_W-1:0]    in_ny,
    input  logic signed [pwb_pkg::NUM_W-1:0]    in_den,
    output logic                                out_valid,
    output logic [PW-1:0]                       out_payload,
    output logic [1:0]                          out_neg,
    output logic [1:0]                          out_ovf,
    output logic [1:0][K-1:0]                   out_q
);
    import pwb_pkg::*;

    localparam int SH  = FRAC_BITS - K;
    localparam int RW0 = NUM_W + SH;

    logic [K:0]             valid_reg;
    logic [PW-1:0]          pay_reg [K+1];
    logic [NUM_W-1:0]       ad_reg  [K+1];
    logic [NUM_W-1:0]       rem_reg [2][K+1];
    logic [K-1:0]           q_reg   [2][K+1];
    logic [1:0]             neg_reg [K+1];
    logic [1:0]             ovf_reg [K+1];

    logic [NUM_W-1:0]       ad_next;
    logic [NUM_W-1:0]       rem0_next [2];
    logic [1:0]             neg0_next;
    logic [1:0]             ovf0_next;
    logic [NUM_W-1:0]       rem_next [2][K+1];
    logic [K-1:0]           q_next   [2][K+1];

    always_comb
    begin
        logic signed [NUM_W-1:0] num;
        logic [NUM_W-1:0]        an;
        logic [RW0-1:0]          r0;
        ad_next = in_den[NUM_W-1] ? NUM_W'(-in_den) : NUM_W'(in_den);
        for (int a = 0; a < 2; a++)
        begin
            num = (a == 0) ? in_nx : in_ny;
            an  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            r0  = {an, {SH{1'b0}}};
            neg0_next[a] = num[NUM_W-1] ^ in_den[NUM_W-1];
            ovf0_next[a] = (r0 >= RW0'(ad_next));
            rem0_next[a] = r0[NUM_W-1:0];
        end
    end

    always_comb
    begin
        logic [NUM_W:0] r2;
        logic [NUM_W:0] rd;
        logic           ge;
        for (int a = 0; a < 2; a++)
        begin
            rem_next[a][0] = rem0_next[a];
            q_next[a][0]   = '0;
            for (int i = 1; i <= K; i++)
            begin
                r2 = {rem_reg[a][i-1], 1'b0};
                rd = {1'b0, ad_reg[i-1]};
                ge = (r2 >= rd);
                r2 = ge ? (r2 - rd) : r2;
                rem_next[a][i] = r2[NUM_W-1:0];
                q_next[a][i]   = {q_reg[a][i-1][K-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[K-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg[0] <= in_payload;
            ad_reg[0]  <= ad_next;
            neg_reg[0] <= neg0_next;
            ovf_reg[0] <= ovf0_next;
            for (int i = 1; i <= K; i++)
            begin
                pay_reg[i] <= pay_reg[i-1];
                ad_reg[i]  <= ad_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
            end
            for (int a = 0; a < 2; a++)
            begin
                for (int i = 0; i <= K; i++)
                begin
                    rem_reg[a][i] <= rem_next[a][i];
                    q_reg[a][i]   <= q_next[a][i];
                end
            end
        end
    end

    assign out_valid   = valid_reg[K];
    assign out_payload = pay_reg[K];
    assign out_neg     = neg_reg[K];
    assign out_ovf     = ovf_reg[K];
    assign out_q[0]    = q_reg[0][K];
    assign out_q[1]    = q_reg[1][K];

endmodule

@@ rtl/core/pwb_store.sv @@
// Source image store in four banks split by column and row parity, so the
// whole 2x2 neighbourhood is read in the same access. Depends on pwb_pkg.
module pwb_store #(
    parameter int XW = 10,
    parameter int YW = 10
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic                        wr_en,
    input  logic [XW-1:0]               wr_x,
    input  logic [YW-1:0]               wr_y,
    input  logic [pwb_pkg::PIX_W-1:0]   wr_data,
    input  logic [XW-1:0]               rd_x0,
    input  logic [XW-1:0]               rd_x1,
    input  logic [YW-1:0]               rd_y0,
    input  logic [YW-1:0]               rd_y1,
    output logic [pwb_pkg::PIX_W-1:0]   p00,
    output logic [pwb_pkg::PIX_W-1:0]   p10,
    output logic [pwb_pkg::PIX_W-1:0]   p01,
    output logic [pwb_pkg::PIX_W-1:0]   p11
);
    import pwb_pkg::*;

    localparam int HXW   = (XW > 1) ? XW - 1 : 1;
    localparam int HYW   = (YW > 1) ? YW - 1 : 1;
    localparam int AW    = HXW + HYW;
    localparam int DEPTH = 2 ** AW;

    function automatic logic [HXW-1:0] half_x(input logic [XW-1:0] v);
        logic [XW:0] t;
        t = {1'b0, v} >> 1;
        return t[HXW-1:0];
    endfunction

    function automatic logic [HYW-1:0] half_y(input logic [YW-1:0] v);
        logic [YW:0] t;
        t = {1'b0, v} >> 1;
        return t[HYW-1:0];
    endfunction

    logic [3:0][PIX_W-1:0] bank_data;
    logic                  px0_reg, px1_reg, py0_reg, py1_reg;

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [PIX_W-1:0] mem_array [DEPTH];
        logic [PIX_W-1:0] rd_reg;
        logic [XW-1:0]    col;
        logic [YW-1:0]    row;
        logic [AW-1:0]    raddr;
        logic [AW-1:0]    waddr;
        logic             we;

        assign col   = (rd_x0[0] == b[0]) ? rd_x0 : rd_x1;
        assign row   = (rd_y0[0] == b[1]) ? rd_y0 : rd_y1;
        assign raddr = {half_y(row), half_x(col)};
        assign waddr = {half_y(wr_y), half_x(wr_x)};
        assign we    = en && wr_en && (wr_x[0] == b[0]) && (wr_y[0] == b[1]);

        always_ff @(posedge clk)
        begin
            if (we)
            begin
                mem_array[waddr] <= wr_data;
            end
            if (en)
            begin
                rd_reg <= mem_array[raddr];
            end
        end

        assign bank_data[b] = rd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px0_reg <= rd_x0[0];
            px1_reg <= rd_x1[0];
            py0_reg <= rd_y0[0];
            py1_reg <= rd_y1[0];
        end
    end

    assign p00 = bank_data[{py0_reg, px0_reg}];
    assign p10 = bank_data[{py0_reg, px1_reg}];
    assign p01 = bank_data[{py1_reg, px0_reg}];
    assign p11 = bank_data[{py1_reg, px1_reg}];

endmodule

@@ rtl/core/pwb_lane.sv @@
// One byte lane of the bilinear blend: four weighted products, sum and round.
// Depends on pwb_pkg.
module pwb_lane (
    input  logic                        clk,
    input  logic                        en,
    input  pwb_pkg::nbr_t               pix,
    input  pwb_pkg::wgt_t               wgt,
    output logic [pwb_pkg::BYTE_W-1:0]  out_byte
);
    import pwb_pkg::*;

    localparam int MW = BYTE_W + WGT_W;
    localparam int SW = MW + 1;

    logic [MW-1:0]     prod_reg [4];
    logic [SW-1:0]     sum_next;
    logic [BYTE_W-1:0] byte_reg;

    always_comb
    begin
        sum_next = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2])
                 + SW'(prod_reg[3]) + SW'(32768);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= MW'(pix.p00) * MW'(wgt.w00);
            prod_reg[1] <= MW'(pix.p10) * MW'(wgt.w10);
            prod_reg[2] <= MW'(pix.p01) * MW'(wgt.w01);
            prod_reg[3] <= MW'(pix.p11) * MW'(wgt.w11);
            byte_reg    <= sum_next[23:16];
        end
    end

    assign out_byte = byte_reg;

endmodule

@@ rtl/core/perspective_warp_bilinear_top.sv @@
// Perspective warp with bilinear sampling: top level with coefficient
// registers, homography products, lane merge and output skid stage.
// Depends on pwb_pkg, pwb_proj, pwb_store and pwb_lane.
//
// The block takes one transaction per clock, loads and requests alike, while
// its output skid stage is empty, and returns one result per request in
// order. K, the quotient width of the divider, is eight plus the wider of
// the two source coordinate widths (18 at the default image size); the
// divider resolves one quotient bit per pipeline stage. Loads
// write the image store at the same pipeline stage where requests read it,
// so every request sees exactly the loads accepted before it. The store is
// four simple dual-port banks of a quarter of the image each and needs no
// clearing pass; a pixel must be loaded before any request samples it.
module perspective_warp_bilinear_top #(
    parameter int MAX_SRC_WIDTH  = 1024,
    parameter int MAX_SRC_HEIGHT = 1024,
    parameter int MAX_DEST_SIZE  = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // coord_x, coord_y, in_byte0, in_byte1, in_byte2, in_byte3
    input  logic [pwb_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // operation
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_byte0, out_byte1, out_byte2, out_byte3
    output logic [pwb_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pwb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pwb_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import pwb_pkg::*;

    localparam int XW = $clog2(MAX_SRC_WIDTH);
    localparam int YW = $clog2(MAX_SRC_HEIGHT);
    localparam int K  = ((XW > YW) ? XW : YW) + 8;
    localparam int PW = 2 + XW + YW + PIX_W;
    localparam logic [15:0] DEST_LIM = 16'(MAX_DEST_SIZE - 1);
    localparam logic [15:0] SRC_W16  = 16'(MAX_SRC_WIDTH);
    localparam logic [15:0] SRC_H16  = 16'(MAX_SRC_HEIGHT);

    // Configuration registers.
    logic [63:0]      coef_pair0_reg, coef_pair1_reg, coef_pair2_reg, coef_pair3_reg;
    logic [31:0]      coef_last_reg;
    logic [DIM_W-1:0] src_width_reg, src_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_pair0_reg <= 64'd65536;
            coef_pair1_reg <= 64'd0;
            coef_pair2_reg <= 64'd65536;
            coef_pair3_reg <= 64'd0;
            coef_last_reg  <= 32'd65536;
            src_width_reg  <= DIM_W'(1024);
            src_height_reg <= DIM_W'(1024);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_COEF_PAIR0: coef_pair0_reg <= cfg_data;
                CFG_COEF_PAIR1: coef_pair1_reg <= cfg_data;
                CFG_COEF_PAIR2: coef_pair2_reg <= cfg_data;
                CFG_COEF_PAIR3: coef_pair3_reg <= cfg_data;
                CFG_COEF_LAST:  coef_last_reg  <= cfg_data[31:0];
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_SRC_HEIGHT: src_height_reg <= cfg_data[DIM_W-1:0];
                default:        ;
            endcase
        end
    end

    logic signed [COEF_W-1:0] m0, m1, m2, m3, m4, m5, m6, m7, m8;
    assign m0 = signed'(coef_pair0_reg[31:0]);
    assign m1 = signed'(coef_pair0_reg[63:32]);
    assign m2 = signed'(coef_pair1_reg[31:0]);
    assign m3 = signed'(coef_pair1_reg[63:32]);
    assign m4 = signed'(coef_pair2_reg[31:0]);
    assign m5 = signed'(coef_pair2_reg[63:32]);
    assign m6 = signed'(coef_pair3_reg[31:0]);
    assign m7 = signed'(coef_pair3_reg[63:32]);
    assign m8 = signed'(coef_last_reg);

    // Effective image size and clamp limits.
    logic [15:0]  w16, h16, s_w16, s_h16, lim_x16, lim_y16;
    logic [K-1:0] top_x, top_y;

    always_comb
    begin
        s_w16   = 16'(src_width_reg);
        s_h16   = 16'(src_height_reg);
        w16     = (s_w16 == 16'd0) ? 16'd1 : ((s_w16 > SRC_W16) ? SRC_W16 : s_w16);
        h16     = (s_h16 == 16'd0) ? 16'd1 : ((s_h16 > SRC_H16) ? SRC_H16 : s_h16);
        lim_x16 = w16 - 16'd1;
        lim_y16 = h16 - 16'd1;
        top_x   = K'({lim_x16[XW-1:0], 8'h00});
        top_y   = K'({lim_y16[YW-1:0], 8'h00});
    end

    // Pipeline enable and output skid stage.
    logic                  en;
    logic                  out_valid_reg, out_valid_next;
    logic                  skid_valid_reg, skid_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [OUT_DATA_W-1:0] skid_data_reg, skid_data_next;
    logic                  in_fire;

    assign en            = ~skid_valid_reg;
    assign s_axis_tready = en;
    assign in_fire       = s_axis_tvalid & en;

    // Stage A: destination clamp and homography products.
    logic [COORD_W-1:0] cx, cy;
    logic [15:0]        cx16, cy16, dxc, dyc;
    logic signed [COORD_W:0] dxs, dys;
    logic               ld_ok;

    assign cx   = s_axis_tdata[11:0];
    assign cy   = s_axis_tdata[23:12];
    assign cx16 = 16'(cx);
    assign cy16 = 16'(cy);
    assign dxc  = (cx16 > DEST_LIM) ? DEST_LIM : cx16;
    assign dyc  = (cy16 > DEST_LIM) ? DEST_LIM : cy16;
    assign dxs  = signed'({1'b0, dxc[COORD_W-1:0]});
    assign dys  = signed'({1'b0, dyc[COORD_W-1:0]});
    assign ld_ok = (cx16 < SRC_W16) && (cy16 < SRC_H16);

    logic                     a_valid_reg;
    logic                     a_op_reg, a_ok_reg;
    logic [XW-1:0]            a_lx_reg;
    logic [YW-1:0]            a_ly_reg;
    logic [PIX_W-1:0]         a_pix_reg;
    logic signed [PROD_W-1:0] a_m0x_reg, a_m1y_reg, a_m3x_reg, a_m4y_reg;
    logic signed [PROD_W-1:0] a_m6x_reg, a_m7y_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_op_reg  <= s_axis_tuser;
            a_ok_reg  <= ld_ok;
            a_lx_reg  <= cx16[XW-1:0];
            a_ly_reg  <= cy16[YW-1:0];
            a_pix_reg <= s_axis_tdata[55:24];
            a_m0x_reg <= PROD_W'(m0) * PROD_W'(dxs);
            a_m1y_reg <= PROD_W'(m1) * PROD_W'(dys);
            a_m3x_reg <= PROD_W'(m3) * PROD_W'(dxs);
            a_m4y_reg <= PROD_W'(m4) * PROD_W'(dys);
            a_m6x_reg <= PROD_W'(m6) * PROD_W'(dxs);
            a_m7y_reg <= PROD_W'(m7) * PROD_W'(dys);
        end
    end

    // Stage B: numerators and denominator.
    logic signed [NUM_W-1:0] nx_next, ny_next, den_sum, den_next;
    logic signed [NUM_W-1:0] b_nx_reg, b_ny_reg, b_den_reg;
    logic                    b_valid_reg;
    logic [PW-1:0]           b_pay_reg;

    always_comb
    begin
        nx_next  = NUM_W'(a_m0x_reg) + NUM_W'(a_m1y_reg) + NUM_W'(m2);
        ny_next  = NUM_W'(a_m3x_reg) + NUM_W'(a_m4y_reg) + NUM_W'(m5);
        den_sum  = NUM_W'(a_m6x_reg) + NUM_W'(a_m7y_reg) + (NUM_W'(m8) <<< 15);
        den_next = (den_sum == '0) ? (NUM_W'(1) <<< 31) : den_sum;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_nx_reg  <= nx_next;
            b_ny_reg  <= ny_next;
            b_den_reg <= den_next;
            b_pay_reg <= {a_op_reg, a_ok_reg, a_lx_reg, a_ly_reg, a_pix_reg};
        end
    end

    // Projective divide.
    logic               p_valid;
    logic [PW-1:0]      p_pay;
    logic [1:0]         p_neg, p_ovf;
    logic [1:0][K-1:0]  p_q;

    pwb_proj #(
        .K  (K),
        .PW (PW)
    ) u_proj (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (b_valid_reg),
        .in_payload  (b_pay_reg),
        .in_nx       (b_nx_reg),
        .in_ny       (b_ny_reg),
        .in_den      (b_den_reg),
        .out_valid   (p_valid),
        .out_payload (p_pay),
        .out_neg     (p_neg),
        .out_ovf     (p_ovf),
        .out_q       (p_q)
    );

    // Stage C: clamp into the image, neighbour coordinates.
    logic [K-1:0]  sx, sy;
    logic [XW-1:0] x0, x1;
    logic [YW-1:0] y0, y1;
    logic [15:0]   x0p1, y0p1;

    always_comb
    begin
        sx = p_neg[0] ? '0 : ((p_ovf[0] || (p_q[0] > top_x)) ? top_x : p_q[0]);
        sy = p_neg[1] ? '0 : ((p_ovf[1] || (p_q[1] > top_y)) ? top_y : p_q[1]);
        x0   = sx[8 +: XW];
        y0   = sy[8 +: YW];
        x0p1 = 16'(x0) + 16'd1;
        y0p1 = 16'(y0) + 16'd1;
        x1   = (x0p1 < w16) ? x0p1[XW-1:0] : x0;
        y1   = (y0p1 < h16) ? y0p1[YW-1:0] : y0;
    end

    logic              c_valid_reg;
    logic              c_op_reg, c_ok_reg;
    logic [XW-1:0]     c_lx_reg, c_x0_reg, c_x1_reg;
    logic [YW-1:0]     c_ly_reg, c_y0_reg, c_y1_reg;
    logic [PIX_W-1:0]  c_pix_reg;
    logic [7:0]        c_fx_reg, c_fy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            {c_op_reg, c_ok_reg, c_lx_reg, c_ly_reg, c_pix_reg} <= p_pay;
            c_x0_reg <= x0;
            c_x1_reg <= x1;
            c_y0_reg <= y0;
            c_y1_reg <= y1;
            c_fx_reg <= sx[7:0];
            c_fy_reg <= sy[7:0];
        end
    end

    // Stage D: store access and blend weights.
    logic [PIX_W-1:0] s_p00, s_p10, s_p01, s_p11;
    logic             wr_en;

    assign wr_en = c_valid_reg && (op_t'(c_op_reg) == OP_LOAD) && c_ok_reg;

    pwb_store #(
        .XW (XW),
        .YW (YW)
    ) u_store (
        .clk     (clk),
        .en      (en),
        .wr_en   (wr_en),
        .wr_x    (c_lx_reg),
        .wr_y    (c_ly_reg),
        .wr_data (c_pix_reg),
        .rd_x0   (c_x0_reg),
        .rd_x1   (c_x1_reg),
        .rd_y0   (c_y0_reg),
        .rd_y1   (c_y1_reg),
        .p00     (s_p00),
        .p10     (s_p10),
        .p01     (s_p01),
        .p11     (s_p11)
    );

    logic [8:0] gx, gy, hx, hy;
    wgt_t       wgt_next, d_wgt_reg;
    logic       d_valid_reg, e_valid_reg, f_valid_reg;

    always_comb
    begin
        gx = 9'(c_fx_reg);
        gy = 9'(c_fy_reg);
        hx = 9'd256 - gx;
        hy = 9'd256 - gy;
        wgt_next.w00 = WGT_W'(hx) * WGT_W'(hy);
        wgt_next.w10 = WGT_W'(gx) * WGT_W'(hy);
        wgt_next.w01 = WGT_W'(hx) * WGT_W'(gy);
        wgt_next.w11 = WGT_W'(gx) * WGT_W'(gy);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_wgt_reg <= wgt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_fire;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= p_valid;
            d_valid_reg <= c_valid_reg && (op_t'(c_op_reg) == OP_REQUEST);
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
        end
    end

    // Byte lanes and merge.
    logic [3:0][BYTE_W-1:0] lane_byte;

    for (genvar c = 0; c < 4; c++)
    begin : g_lane
        nbr_t lane_pix;

        assign lane_pix.p00 = s_p00[8*c +: 8];
        assign lane_pix.p10 = s_p10[8*c +: 8];
        assign lane_pix.p01 = s_p01[8*c +: 8];
        assign lane_pix.p11 = s_p11[8*c +: 8];

        pwb_lane u_lane (
            .clk      (clk),
            .en       (en),
            .pix      (lane_pix),
            .wgt      (d_wgt_reg),
            .out_byte (lane_byte[c])
        );
    end

    logic out_fire;
    assign out_fire = out_valid_reg & m_axis_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (f_valid_reg)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_next = 1'b1;
                out_data_next  = lane_byte;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = lane_byte;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
